// ===== design/gb_pkg.sv =====
// ---------------------------------------------------------------------------
// gb_pkg: shared types and constants for the 3x3 Gaussian blur
// Field widths, configuration register indexes, the column-sum type that
// moves along the window cells, and the control word of the result stage.
// ---------------------------------------------------------------------------
package gb_pkg;

	localparam int PIX_W      = 8;
	localparam int VSUM_W     = 10;   // p0 + 2*p1 + p2 <= 1020
	localparam int HSUM_W     = 12;   // full 3x3 weighted sum <= 4080
	localparam int OUT_COL_W  = 10;
	localparam int ROW_W      = 16;
	localparam int IMG_W_W    = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_COLS   = 3;
	localparam int N_RES      = 4;

	localparam int IMG_W_RESET = 1024;
	localparam int IMG_H_RESET = 1024;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// result slots of one input, in raster order
	localparam int RES_UP_LEFT  = 0;  // (x-1, y-1)
	localparam int RES_UP_EDGE  = 1;  // (x,   y-1) at last column
	localparam int RES_CUR_LEFT = 2;  // (x-1, y)   in last row
	localparam int RES_CUR_EDGE = 3;  // (x,   y)   last row, last column

	typedef struct packed {
		logic [VSUM_W-1:0] full;  // rows two-above, above, current: 1-2-1
		logic [VSUM_W-1:0] bot;   // bottom edge: row above 1, mirrored current row 3
		logic [VSUM_W-1:0] solo;  // bottom edge on row 0: current row alone, 4
	} col_sum_t;

	typedef struct packed {
		logic [N_RES-1:0] mask;
		logic             x_is0;
		logic             x_is1;
	} emit_ctl_t;

	function automatic col_sum_t col_sums(input logic [PIX_W-1:0] p0,
	                                      input logic [PIX_W-1:0] p1,
	                                      input logic [PIX_W-1:0] p2);
		col_sum_t s;
		s.full = {2'b00, p0} + {1'b0, p1, 1'b0} + {2'b00, p2};
		s.bot  = {2'b00, p1} + {2'b00, p2} + {1'b0, p2, 1'b0};
		s.solo = {p2, 2'b00};
		return s;
	endfunction

endpackage

// ===== design/gb_linebuf.sv =====
// ---------------------------------------------------------------------------
// gb_linebuf: two line buffers of the blur
// Row above and row two above, one entry per column. The row-above memory is
// read and rewritten at the same column on each input transfer (old data
// comes out); the row-two-above memory is written one stage later.
// ---------------------------------------------------------------------------
module gb_linebuf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	input  logic [gb_pkg::PIX_W-1:0] above_wdata,
	input  logic                    two_we,
	input  logic [AW-1:0]           two_waddr,
	input  logic [gb_pkg::PIX_W-1:0] two_wdata,
	output logic [gb_pkg::PIX_W-1:0] above_q,
	output logic [gb_pkg::PIX_W-1:0] two_q
);
	import gb_pkg::*;

	logic [PIX_W-1:0] above_mem [DEPTH];
	logic [PIX_W-1:0] two_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			above_q            <= above_mem[rd_addr];
			above_mem[rd_addr] <= above_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			two_q <= two_mem[rd_addr];
		end
		if (two_we) begin
			two_mem[two_waddr] <= two_wdata;
		end
	end

endmodule

// ===== design/gb_cell.sv =====
// ---------------------------------------------------------------------------
// gb_cell: one column of the 3x3 window
// Holds the vertical sums of one source column and passes them to the
// older neighbor whenever the window advances.
// ---------------------------------------------------------------------------
module gb_cell (
	input  logic             clk,
	input  logic             shift,
	input  gb_pkg::col_sum_t d,
	output gb_pkg::col_sum_t q
);
	import gb_pkg::*;

	col_sum_t col_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= d;
		end
	end

	assign q = col_q;

endmodule

// ===== design/gb_emit.sv =====
// ---------------------------------------------------------------------------
// gb_emit: result sequencer and output register
// Takes the pending result slots of one input, forms one horizontal 1-2-1
// sum per cycle from the window cells unless a stalled result is held, and
// drives the output channel.
module gb_emit #(
	parameter int CW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  gb_pkg::emit_ctl_t             ctl_in,
	input  logic [CW-1:0]                 x_in,
	input  logic [gb_pkg::ROW_W-1:0]      y_in,
	input  gb_pkg::col_sum_t              win_left,
	input  gb_pkg::col_sum_t              win_mid,
	input  gb_pkg::col_sum_t              win_right,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [gb_pkg::PIX_W-1:0]      pixel_out,
	output logic [gb_pkg::OUT_COL_W-1:0]  out_col,
	output logic [gb_pkg::ROW_W-1:0]      out_row,
	output logic                          frame_last
);
	import gb_pkg::*;

	logic [N_RES-1:0]  mask_q;
	logic              x_is0_q;
	logic              x_is1_q;
	logic [CW-1:0]     x_q;
	logic [ROW_W-1:0]  y_q;
	logic              out_valid_q;

	logic [N_RES-1:0]  sel;
	logic [N_RES-1:0]  mask_nxt;
	logic              fire;
	logic              use_full;
	logic              use_above;
	logic              at_edge;
	logic [VSUM_W-1:0] vl;
	logic [VSUM_W-1:0] vm;
	logic [VSUM_W-1:0] vr;
	logic [VSUM_W-1:0] va;
	logic [VSUM_W-1:0] vb;
	logic [VSUM_W-1:0] vc;
	logic [HSUM_W-1:0] hsum;
	logic [CW-1:0]     col;
	logic [ROW_W-1:0]  row;

	always_comb begin
		sel      = mask_q & (~mask_q + 1'b1);
		mask_nxt = mask_q & ~sel;
		fire     = (mask_q != '0) && (!out_valid_q || !out_stall);
		ready    = (mask_q == '0) || (fire && (mask_nxt == '0));
		use_full = sel[RES_UP_LEFT] | sel[RES_UP_EDGE];
		at_edge  = sel[RES_UP_EDGE] | sel[RES_CUR_EDGE];

		// bottom row: row above plus mirrored current row, current row alone on row 0
		use_above = (y_q != '0);
		vl = use_full ? win_left.full  : (use_above ? win_left.bot  : win_left.solo);
		vm = use_full ? win_mid.full   : (use_above ? win_mid.bot   : win_mid.solo);
		vr = use_full ? win_right.full : (use_above ? win_right.bot : win_right.solo);

		// left neighbor mirrors at column 0, right neighbor at the last column
		if (at_edge) begin
			va = x_is0_q ? vr : vm;
			vb = vr;
		end else begin
			va = x_is1_q ? vm : vl;
			vb = vm;
		end
		vc = vr;

		hsum = {2'b00, va} + {1'b0, vb, 1'b0} + {2'b00, vc};
		col  = at_edge ? x_q : x_q - 1'b1;
		row  = use_full ? y_q - 1'b1 : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= ctl_in.mask;
			end else if (fire) begin
				mask_q <= mask_nxt;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_is0_q <= ctl_in.x_is0;
			x_is1_q <= ctl_in.x_is1;
			x_q     <= x_in;
			y_q     <= y_in;
		end
		if (fire) begin
			pixel_out  <= hsum[HSUM_W-1:HSUM_W-PIX_W];
			out_col    <= OUT_COL_W'(col);
			out_row    <= row;
			frame_last <= sel[RES_CUR_EDGE];
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/gauss3x3_blur_mirror_border.sv =====
// ---------------------------------------------------------------------------
// gauss3x3_blur_mirror_border: streaming 3x3 Gaussian blur, mirrored borders
// Kernel 1-2-1/2-4-2/1-2-1, sum divided by 16 (truncated).
// ---------------------------------------------------------------------------
// Usage:
//  Source pixels enter in raster order on in_valid/in_stall/pixel_in; a
//  transfer happens when in_valid is high and in_stall is low. Results leave
//  on out_valid/out_stall with their column, row and frame_last flag.
//  image_width (index 0) and image_height (index 1) are written on the cfg
//  channel (cfg_ready is always high) while no item is in flight.
//  An input passes the stage 1 register, the result stage and the output
//  register. Throughput: one pixel per clock while the output does not
//  stall. An input that produces more than one result (last column or last
//  row: two, last column of last row: four) holds the input until its extra
//  results are formed; the output stage's single result sequencer sets this.
//  A stalled output holds its result; the item behind it waits in the
//  result stage and the stage before it, then in_stall rises.
//  Reset clears counters and pipeline; width and height go to 1024 (width
//  capped at MAX_WIDTH). The line buffers are not cleared; a row is always
//  written before it is read, so no clearing pass runs after reset.
// ---------------------------------------------------------------------------
module gauss3x3_blur_mirror_border #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gb_pkg::PIX_W-1:0]        pixel_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gb_pkg::PIX_W-1:0]        pixel_out,
	output logic [gb_pkg::OUT_COL_W-1:0]    out_col,
	output logic [gb_pkg::ROW_W-1:0]        out_row,
	output logic                            frame_last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gb_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gb_pkg::*;

	localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RESET_W = (MAX_WIDTH < IMG_W_RESET) ? MAX_WIDTH : IMG_W_RESET;
	localparam logic [CW-1:0]    W_LAST_RST = CW'(RESET_W - 1);
	localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(IMG_H_RESET - 1);

	// configuration, kept as last column / last row index
	logic [CW-1:0]      w_last_q;
	logic [ROW_W-1:0]   h_last_q;
	logic [IMG_W_W-1:0] w_raw;
	logic [CW-1:0]      w_last_cfg;
	logic [ROW_W-1:0]   h_last_cfg;

	// position of next input
	logic [CW-1:0]      col_count_q;
	logic [ROW_W-1:0]   row_count_q;
	logic [CW-1:0]      x_cur;
	logic [ROW_W-1:0]   y_cur;
	logic               x_end;
	logic               y_end;
	logic               x_ge1;
	logic               y_ge1;
	emit_ctl_t          ctl_cur;

	// stage 1: line buffer read data comes back
	logic               valid_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [CW-1:0]      x_s1;
	logic [ROW_W-1:0]   y_s1;
	emit_ctl_t          ctl_s1;
	logic               y_ge2_s1;
	logic               fwd_s1;
	logic [PIX_W-1:0]   two_fwd_q;
	logic [PIX_W-1:0]   above_rd_s1;
	logic [PIX_W-1:0]   two_rd_s1;
	logic [PIX_W-1:0]   two_val;
	col_sum_t           new_col;

	logic               accept;
	logic               adv2;
	logic               s2_ready;
	col_sum_t           win [WIN_COLS];

	assign cfg_ready = 1'b1;

	always_comb begin
		w_raw = cfg_data[IMG_W_W-1:0];
		if (w_raw == '0) begin
			w_last_cfg = '0;
		end else if (32'(w_raw) > 32'(MAX_WIDTH)) begin
			w_last_cfg = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_cfg = CW'(w_raw - 1'b1);
		end
		h_last_cfg = (cfg_data == '0) ? '0 : cfg_data - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= W_LAST_RST;
			h_last_q <= H_LAST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  w_last_q <= w_last_cfg;
				CFG_IMAGE_HEIGHT: h_last_q <= h_last_cfg;
				default: ;
			endcase
		end
	end

	// handshake
	assign in_stall = valid_s1 && !s2_ready;
	assign accept   = in_valid && !in_stall;
	assign adv2     = valid_s1 && s2_ready;

	always_comb begin
		// counts beyond a shrunk frame clamp to the last column / row
		x_cur = (col_count_q > w_last_q) ? w_last_q : col_count_q;
		y_cur = (row_count_q > h_last_q) ? h_last_q : row_count_q;
		x_end = (x_cur == w_last_q);
		y_end = (y_cur == h_last_q);
		x_ge1 = (x_cur != '0);
		y_ge1 = (y_cur != '0);
		ctl_cur.mask[RES_UP_LEFT]  = y_ge1 && x_ge1;
		ctl_cur.mask[RES_UP_EDGE]  = y_ge1 && x_end;
		ctl_cur.mask[RES_CUR_LEFT] = y_end && x_ge1;
		ctl_cur.mask[RES_CUR_EDGE] = y_end && x_end;
		ctl_cur.x_is0 = !x_ge1;
		ctl_cur.x_is1 = (x_cur == CW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			col_count_q <= '0;
			row_count_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (x_end) begin
					col_count_q <= '0;
					row_count_q <= y_end ? '0 : y_cur + 1'b1;
				end else begin
					col_count_q <= x_cur + 1'b1;
					row_count_q <= y_cur;
				end
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pixel_in;
			x_s1      <= x_cur;
			y_s1      <= y_cur;
			ctl_s1    <= ctl_cur;
			y_ge2_s1  <= (y_cur[ROW_W-1:1] != '0);
			// row-two-above write of the leaving item lands at the same edge
			fwd_s1    <= adv2 && (x_s1 == x_cur);
			two_fwd_q <= above_rd_s1;
		end
	end

	gb_linebuf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_gb_linebuf (
		.clk         (clk),
		.rd_en       (accept),
		.rd_addr     (x_cur),
		.above_wdata (pixel_in),
		.two_we      (adv2),
		.two_waddr   (x_s1),
		.two_wdata   (above_rd_s1),
		.above_q     (above_rd_s1),
		.two_q       (two_rd_s1)
	);

	always_comb begin
		two_val = fwd_s1 ? two_fwd_q : two_rd_s1;
		// on row 1 the row above stands in for the missing row two above
		new_col = col_sums(y_ge2_s1 ? two_val : above_rd_s1, above_rd_s1, pix_s1);
	end

	for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
		if (i == WIN_COLS - 1) begin : g_head
			gb_cell u_gb_cell (
				.clk   (clk),
				.shift (adv2),
				.d     (new_col),
				.q     (win[i])
			);
		end else begin : g_body
			gb_cell u_gb_cell (
				.clk   (clk),
				.shift (adv2),
				.d     (win[i+1]),
				.q     (win[i])
			);
		end
	end

	gb_emit #(
		.CW (CW)
	) u_gb_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv2),
		.ctl_in     (ctl_s1),
		.x_in       (x_s1),
		.y_in       (y_s1),
		.win_left   (win[0]),
		.win_mid    (win[1]),
		.win_right  (win[2]),
		.ready      (s2_ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.out_col    (out_col),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

endmodule

// ===== design/gb_checker.sv =====
// ---------------------------------------------------------------------------
// gb_checker: port-level checks of the Gaussian blur
// Output channel behavior under stall and after reset.
// ---------------------------------------------------------------------------
module gb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [gb_pkg::PIX_W-1:0]        pixel_out,
	input logic [gb_pkg::OUT_COL_W-1:0]    out_col,
	input logic [gb_pkg::ROW_W-1:0]        out_row,
	input logic                            frame_last
);
	import gb_pkg::*;

	logic seen_in_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			seen_in_q <= 1'b1;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// a result needs at least one input transfer since reset
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("result with no input since reset");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(out_col)
		&& $stable(out_row) && $stable(frame_last))
		else $error("stalled result changed");

endmodule

bind gauss3x3_blur_mirror_border gb_checker u_gb_checker (.*);
